[rtl/uss_pkg.sv]
package uss_pkg;

  // Default sizes
  localparam int unsigned MaxNeedleDflt = 16;
  localparam int unsigned PosBitsDflt   = 16;

  // Field widths fixed by the interface
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 5;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned MPosW   = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegNeedleLo = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNeedleHi = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNeedleLen = 2'd2;

  // Result codes
  localparam logic [StatW-1:0] StFound    = 2'd0;
  localparam logic [StatW-1:0] StNotFound = 2'd1;
  localparam logic [StatW-1:0] StUnclosed = 2'd2;
  localparam logic [StatW-1:0] StTooLong  = 2'd3;

  localparam logic [ByteW-1:0] SQuote = 8'h27;
  localparam logic [ByteW-1:0] DQuote = 8'h22;

  typedef enum logic [2:0] {
    QOut    = 3'b001,
    QSingle = 3'b010,
    QDouble = 3'b100
  } qmode_e;

  // Window control from the scan stage
  typedef struct packed {
    logic step;   // shift in the current byte
    logic clear;  // end of string
    logic ok;     // current byte may start a match
  } win_ctrl_t;

  function automatic logic [ByteW-1:0] fold(input logic [ByteW-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

[rtl/unquoted_substring_search_top.sv]
// Unquoted case-insensitive substring search.
//
// Input channel: one haystack byte per word (text_byte_i, is_last_i), handed
// over with in_valid_i / in_stall_o. Output channel: at most one word per
// string (status_o, match_pos_o) with out_valid_o / out_stall_i.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 needle bytes 0..7, 1 needle bytes 8..15, 2 needle length); write only
// while the block is idle. Index 3 is ignored.
//
// Each accepted byte waits in the input register; its result is loaded into
// the result register when the byte leaves it, which it cannot do while a
// result is stalled. Throughput: one byte per cycle while the receiver does
// not stall; the window compare runs in parallel over all needle positions.
// A found result comes on the byte completing the match, a too-long one on
// the first byte after the position counter is full, any other verdict on
// the byte marked last; later bytes of that string are consumed silently.
//
// Reset clears the needle (length 1), the window and all per-string state.
// When the receiver stalls a waiting result, the result register holds and
// the byte in the input register waits behind it; an empty input register
// still takes one byte, then in_stall_o stays high until the result leaves.
module unquoted_substring_search_top #(
  parameter int unsigned MAX_NEEDLE = uss_pkg::MaxNeedleDflt,
  parameter int unsigned POS_BITS   = uss_pkg::PosBitsDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          cfg_we_i,
  input  logic [uss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [uss_pkg::CfgW-1:0]      cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [uss_pkg::ByteW-1:0]     text_byte_i,
  input  logic                          is_last_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [uss_pkg::StatW-1:0]     status_o,
  output logic [uss_pkg::MPosW-1:0]     match_pos_o
);

  localparam logic [uss_pkg::LenW-1:0] MaxLen = uss_pkg::LenW'(MAX_NEEDLE);

  // Config registers
  logic [uss_pkg::CfgW-1:0] ndl_lo_q, ndl_hi_q;
  logic [uss_pkg::LenW-1:0] ndl_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndl_lo_q  <= '0;
      ndl_hi_q  <= '0;
      ndl_len_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uss_pkg::RegNeedleLo:  ndl_lo_q  <= cfg_data_i;
        uss_pkg::RegNeedleHi:  ndl_hi_q  <= cfg_data_i;
        uss_pkg::RegNeedleLen: ndl_len_q <= cfg_data_i[uss_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: 0 acts as 1, clamp to MAX_NEEDLE
  logic [uss_pkg::LenW-1:0] n_eff;
  always_comb begin
    n_eff = ndl_len_q;
    if (n_eff == '0) n_eff = 5'd1;
    if (n_eff > MaxLen) n_eff = MaxLen;
  end

  logic [MAX_NEEDLE-1:0][uss_pkg::ByteW-1:0] needle;
  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_ndl
    if (j < 8) begin : g_lo
      assign needle[j] = ndl_lo_q[8*j +: 8];
    end else begin : g_hi
      assign needle[j] = ndl_hi_q[8*(j-8) +: 8];
    end
  end

  // Input register
  logic                       s1_valid_q;
  logic [uss_pkg::ByteW-1:0]  s1_byte_q;
  logic                       s1_last_q;
  logic                       s1_go, in_acc;

  assign s1_go      = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= is_last_i;
    end
  end

  // Per-string scan state
  uss_pkg::qmode_e      qmode_q, qmode_d;
  logic [POS_BITS-1:0]  oq_pos_q, oq_pos_d;
  logic [POS_BITS-1:0]  cnt_q, cnt_d;
  logic                 answered_q, answered_d;

  logic                 too_long, do_step, is_sq, is_dq, hit;
  logic                 found, fin, res, unclosed;
  uss_pkg::win_ctrl_t   wctl;
  logic [uss_pkg::StatW-1:0] res_stat;
  logic [31:0]               res_pos;

  assign is_sq    = (s1_byte_q == uss_pkg::SQuote);
  assign is_dq    = (s1_byte_q == uss_pkg::DQuote);
  assign too_long = (cnt_q == '1);
  assign do_step  = !answered_q && !too_long;

  always_comb begin
    qmode_d  = qmode_q;
    oq_pos_d = oq_pos_q;
    unique case (qmode_q)
      uss_pkg::QOut: begin
        if (is_sq) begin
          qmode_d  = uss_pkg::QSingle;
          oq_pos_d = cnt_q;
        end else if (is_dq) begin
          qmode_d  = uss_pkg::QDouble;
          oq_pos_d = cnt_q;
        end
      end
      uss_pkg::QSingle: if (is_sq) qmode_d = uss_pkg::QOut;
      uss_pkg::QDouble: if (is_dq) qmode_d = uss_pkg::QOut;
      default:          qmode_d = uss_pkg::QOut;
    endcase
  end

  assign wctl.step  = s1_go && do_step;
  assign wctl.clear = s1_go && s1_last_q;
  assign wctl.ok    = (qmode_q == uss_pkg::QOut) && !is_sq && !is_dq;

  uss_window #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (wctl),
    .byte_i   (s1_byte_q),
    .needle_i (needle),
    .len_i    (n_eff),
    .hit_o    (hit)
  );

  assign found = do_step && hit;
  assign fin   = do_step && !hit && s1_last_q;
  assign res   = !answered_q && (too_long || found || fin);

  // Open span counts only if it opened early enough for a match to fit
  assign unclosed = (qmode_d != uss_pkg::QOut) &&
                    (({1'b0, oq_pos_d} + (POS_BITS+1)'(n_eff)) <=
                     ({1'b0, cnt_q} + (POS_BITS+1)'(1)));

  assign res_pos = 32'(cnt_q) + 32'd2 - 32'(n_eff);

  always_comb begin
    if (too_long)      res_stat = uss_pkg::StTooLong;
    else if (found)    res_stat = uss_pkg::StFound;
    else if (unclosed) res_stat = uss_pkg::StUnclosed;
    else               res_stat = uss_pkg::StNotFound;
  end

  always_comb begin
    cnt_d      = cnt_q;
    answered_d = answered_q;
    if (do_step) cnt_d = cnt_q + POS_BITS'(1);
    if (res)     answered_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qmode_q    <= uss_pkg::QOut;
      oq_pos_q   <= '0;
      cnt_q      <= '0;
      answered_q <= 1'b0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        qmode_q    <= uss_pkg::QOut;
        oq_pos_q   <= '0;
        cnt_q      <= '0;
        answered_q <= 1'b0;
      end else begin
        if (do_step) begin
          qmode_q  <= qmode_d;
          oq_pos_q <= oq_pos_d;
        end
        cnt_q      <= cnt_d;
        answered_q <= answered_d;
      end
    end
  end

  // Result register
  logic                       out_valid_q;
  logic [uss_pkg::StatW-1:0]  status_q;
  logic [uss_pkg::MPosW-1:0]  pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res) begin
      status_q <= res_stat;
      pos_q    <= (found && !too_long) ? res_pos[uss_pkg::MPosW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign match_pos_o = pos_q;

endmodule

[rtl/uss_window.sv]
module uss_window #(
  parameter int unsigned MAX_NEEDLE = uss_pkg::MaxNeedleDflt
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  uss_pkg::win_ctrl_t                         ctrl_i,
  input  logic [uss_pkg::ByteW-1:0]                  byte_i,
  input  logic [MAX_NEEDLE-1:0][uss_pkg::ByteW-1:0]  needle_i,
  input  logic [uss_pkg::LenW-1:0]                   len_i,
  output logic                                       hit_o
);

  // Older bytes only; the newest byte comes straight from byte_i.
  localparam int unsigned Win = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int unsigned IdxW = (Win > 1) ? $clog2(Win) : 1;

  logic [Win-1:0][uss_pkg::ByteW-1:0] win_q, win_d;
  logic [Win-1:0]                     okf_q, okf_d;
  logic [MAX_NEEDLE-1:0]              eq;
  logic                               start_ok;
  logic [uss_pkg::LenW-1:0]           lenm2;

  always_comb begin
    win_d = win_q;
    okf_d = okf_q;
    if (ctrl_i.clear) begin
      win_d = '0;
      okf_d = '0;
    end else if (ctrl_i.step) begin
      win_d[0] = byte_i;
      okf_d[0] = ctrl_i.ok;
      for (int k = 1; k < Win; k++) begin
        win_d[k] = win_q[k-1];
        okf_d[k] = okf_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      okf_q <= '0;
    end else begin
      win_q <= win_d;
      okf_q <= okf_d;
    end
  end

  // Needle byte j lines up with window slot len-1-j (slot 0 = current byte).
  always_comb begin
    logic [uss_pkg::LenW-1:0] sel;
    logic [uss_pkg::LenW-1:0] selm1;
    logic [uss_pkg::ByteW-1:0] wb;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      sel   = len_i - 5'd1 - uss_pkg::LenW'(j);
      selm1 = sel - 5'd1;
      wb    = (sel == '0) ? byte_i : win_q[selm1[IdxW-1:0]];
      eq[j] = (uss_pkg::LenW'(j) >= len_i) ||
              (uss_pkg::fold(wb) == uss_pkg::fold(needle_i[j]));
    end
  end

  assign lenm2    = len_i - 5'd2;
  assign start_ok = (len_i == 5'd1) ? ctrl_i.ok : okf_q[lenm2[IdxW-1:0]];
  assign hit_o    = start_ok && (&eq);

endmodule

[tb/tb.sv]
module tb;

  // Longest string the block accepts before it flags it as too long.
  localparam int unsigned PosLimit = (1 << uss_pkg::PosBitsDflt) - 1;
  // Margin after the block drains, before config writes.
  localparam int unsigned DrainCycles = 8;
  // Cycles with no handshake on either side before we call it hung.
  localparam int unsigned StuckLimit = 2000;
  // Long receiver hold-off that backs the block up into its input.
  localparam int unsigned SqueezeCycles = 150;
  localparam int unsigned IdlePct = 35;
  // Random bytes per config setting.
  localparam int unsigned PhaseBytes = 300;
  // Index with no register behind it; writes there must be dropped.
  localparam logic [uss_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [uss_pkg::ByteW-1:0] text;
    logic                      last;
  } text_word_t;

  typedef struct packed {
    logic [uss_pkg::StatW-1:0] status;
    logic [uss_pkg::MPosW-1:0] pos;
  } verdict_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [uss_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [uss_pkg::CfgW-1:0]     cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [uss_pkg::ByteW-1:0]    text_byte_i = '0;
  logic                         is_last_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [uss_pkg::StatW-1:0]    status_o;
  logic [uss_pkg::MPosW-1:0]    match_pos_o;

  text_word_t pending_words [$];  // words waiting for the driver
  verdict_t   verdicts_due [$];   // predicted results, oldest first
  text_word_t drive_word;
  verdict_t   due;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // No idling at all while set.
  bit calm = 1'b0;
  // Hold-off requests from the stimulus side, served by the receiver.
  int unsigned squeeze_asked = 0;
  int unsigned squeeze_given = 0;
  int unsigned squeeze_left = 0;

  // Predictor copy of the registers and per-string state.
  logic [uss_pkg::CfgW-1:0]  needle_lo_cfg  = '0;
  logic [uss_pkg::CfgW-1:0]  needle_hi_cfg  = '0;
  logic [uss_pkg::LenW-1:0]  needle_len_cfg = 5'd1;
  logic [uss_pkg::ByteW-1:0] hay_window [uss_pkg::MaxNeedleDflt];  // newest byte at 0
  logic [uss_pkg::MaxNeedleDflt-1:0] start_flags;
  uss_pkg::qmode_e           quote_state;
  int unsigned               quote_open_at;
  int unsigned               bytes_seen;
  bit                        verdict_given;

  // Needle the stimulus side is about to program.
  logic [uss_pkg::ByteW-1:0] plan_bytes [uss_pkg::MaxNeedleDflt];
  int unsigned               plan_len;

  unquoted_substring_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .match_pos_o (match_pos_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Needle length field as the block uses it: 0 behaves as 1, big values clamp.
  function automatic int unsigned active_len(input logic [uss_pkg::LenW-1:0] len_field);
    if (len_field == 0) return 1;
    if (len_field > uss_pkg::MaxNeedleDflt) return uss_pkg::MaxNeedleDflt;
    return len_field;
  endfunction

  // ASCII-only case fold; other bytes pass through untouched.
  function automatic logic [uss_pkg::ByteW-1:0] lower_ascii(
      input logic [uss_pkg::ByteW-1:0] c);
    if (c inside {[8'h41:8'h5A]}) return c | 8'h20;
    return c;
  endfunction

  function automatic logic [uss_pkg::ByteW-1:0] needle_at(input int unsigned j);
    if (j < 8) return needle_lo_cfg[8*j +: 8];
    return needle_hi_cfg[8*(j-8) +: 8];
  endfunction

  task automatic clear_string_state();
    int k;
    for (k = 0; k < uss_pkg::MaxNeedleDflt; k++) hay_window[k] = '0;
    start_flags   = '0;
    quote_state   = uss_pkg::QOut;
    quote_open_at = 0;
    bytes_seen    = 0;
    verdict_given = 1'b0;
  endtask

  // Advance the model by one accepted word; queue the verdict it causes.
  task automatic predict_verdict(input logic [uss_pkg::ByteW-1:0] b, input logic last);
    int unsigned n;
    int unsigned start_pos;
    int k;
    bit can_start;
    bit hit;
    verdict_t v;
    n = active_len(needle_len_cfg);
    if (!verdict_given) begin
      if (bytes_seen >= PosLimit) begin
        // too long beats a match landing on the same byte
        v.status = uss_pkg::StTooLong;
        v.pos = '0;
        verdicts_due.push_back(v);
        verdict_given = 1'b1;
      end else begin
        // quotes never start a match, nor does anything inside a span
        can_start = (quote_state == uss_pkg::QOut) && (b != uss_pkg::SQuote) &&
                    (b != uss_pkg::DQuote);
        case (quote_state)
          uss_pkg::QOut: begin
            if (b == uss_pkg::SQuote) begin
              quote_state = uss_pkg::QSingle;
              quote_open_at = bytes_seen;
            end else if (b == uss_pkg::DQuote) begin
              quote_state = uss_pkg::QDouble;
              quote_open_at = bytes_seen;
            end
          end
          uss_pkg::QSingle: begin
            if (b == uss_pkg::SQuote) quote_state = uss_pkg::QOut;
          end
          default: begin
            if (b == uss_pkg::DQuote) quote_state = uss_pkg::QOut;
          end
        endcase
        for (k = uss_pkg::MaxNeedleDflt - 1; k > 0; k--) hay_window[k] = hay_window[k-1];
        hay_window[0] = b;
        start_flags = {start_flags[uss_pkg::MaxNeedleDflt-2:0], can_start};
        bytes_seen++;

        hit = start_flags[n-1];
        for (k = 0; k < n; k++) begin
          if (lower_ascii(hay_window[n-1-k]) != lower_ascii(needle_at(k))) hit = 1'b0;
        end

        if (hit) begin
          start_pos = bytes_seen + 1 - n;
          v.status = uss_pkg::StFound;
          v.pos = start_pos[uss_pkg::MPosW-1:0];
          verdicts_due.push_back(v);
          verdict_given = 1'b1;
        end else if (last) begin
          // open span counts only if a full needle could have fit after it
          if (quote_state != uss_pkg::QOut && quote_open_at + n <= bytes_seen)
            v.status = uss_pkg::StUnclosed;
          else v.status = uss_pkg::StNotFound;
          v.pos = '0;
          verdicts_due.push_back(v);
          verdict_given = 1'b1;
        end
      end
    end
    if (last) clear_string_state();
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // Driver: one word per accepted handshake, random idle cycles
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        drive_word = pending_words.pop_front();
        in_valid_i  <= 1'b1;
        text_byte_i <= drive_word.text;
        is_last_i   <= drive_word.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall, plus long hold-offs on request
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (squeeze_left != 0) begin
      squeeze_left--;
      out_stall_i <= 1'b1;
    end else if (squeeze_given != squeeze_asked) begin
      squeeze_given++;
      squeeze_left = SqueezeCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: mirror config, predict on input words, check output words
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          uss_pkg::RegNeedleLo:  needle_lo_cfg  = cfg_data_i;
          uss_pkg::RegNeedleHi:  needle_hi_cfg  = cfg_data_i;
          uss_pkg::RegNeedleLen: needle_len_cfg = cfg_data_i[uss_pkg::LenW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_verdict(text_byte_i, is_last_i);
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected word status=%0d pos=%0d",
                                  status_o, match_pos_o));
        end else begin
          due = verdicts_due.pop_front();
          if (status_o !== due.status)
            flag_mismatch($sformatf("status %0d, want %0d", status_o, due.status));
          if (match_pos_o !== due.pos)
            flag_mismatch($sformatf("match_pos %0d, want %0d", match_pos_o, due.pos));
        end
      end
    end
  end

  // Watchdog: too long without any handshake means the block is hung.
  initial begin
    while (quiet_cycles < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic logic [uss_pkg::ByteW-1:0] shuffle_case(
      input logic [uss_pkg::ByteW-1:0] c);
    if ($urandom_range(1) && (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})) return c ^ 8'h20;
    return c;
  endfunction

  task automatic push_word(input logic [uss_pkg::ByteW-1:0] b, input logic last);
    text_word_t w;
    w.text = b;
    w.last = last;
    pending_words.push_back(w);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
  endtask

  // Wait until the block has nothing in flight, then a few spare cycles.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid_i || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Program plan_bytes and the given length word; optionally hit the dead index.
  task automatic load_needle(input logic [uss_pkg::CfgW-1:0] len_word,
                             input bit poke_unused);
    logic [uss_pkg::CfgW-1:0] lo;
    logic [uss_pkg::CfgW-1:0] hi;
    int i;
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = plan_bytes[i];
      hi[8*i +: 8] = plan_bytes[8+i];
    end
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= uss_pkg::RegNeedleLo;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= uss_pkg::RegNeedleHi;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_idx_i  <= uss_pkg::RegNeedleLen;
    cfg_data_i <= len_word;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_idx_i  <= RegUnused;
      cfg_data_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    plan_len = active_len(len_word[uss_pkg::LenW-1:0]);
  endtask

  // Mostly letters, some quotes and digits, the odd raw byte.
  task automatic roll_needle();
    int i;
    int unsigned pick;
    for (i = 0; i < uss_pkg::MaxNeedleDflt; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) plan_bytes[i] = shuffle_case(8'h61 + 8'($urandom_range(25)));
      else if (pick < 68) plan_bytes[i] = $urandom_range(1) ? uss_pkg::SQuote : uss_pkg::DQuote;
      else if (pick < 80) plan_bytes[i] = 8'h30 + 8'($urandom_range(9));
      else plan_bytes[i] = 8'($urandom_range(255));
    end
  endtask

  // One string built around the needle: whole copies, needle bytes, quotes, noise.
  task automatic push_random_string(input int unsigned len, output int unsigned pushed);
    logic [uss_pkg::ByteW-1:0] chars [$];
    int unsigned pick;
    int i;
    while (chars.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        for (i = 0; i < plan_len; i++) chars.push_back(shuffle_case(plan_bytes[i]));
      end else if (pick < 25) begin
        chars.push_back($urandom_range(1) ? uss_pkg::SQuote : uss_pkg::DQuote);
      end else if (pick < 60) begin
        chars.push_back(shuffle_case(plan_bytes[$urandom_range(plan_len - 1)]));
      end else if (pick < 75) begin
        chars.push_back(shuffle_case(8'h61 + 8'($urandom_range(25))));
      end else begin
        chars.push_back(8'($urandom_range(255)));
      end
    end
    for (i = 0; i < chars.size(); i++) push_word(chars[i], i == chars.size() - 1);
    pushed = chars.size();
  endtask

  task automatic run_random_phase(input logic [uss_pkg::CfgW-1:0] len_word,
                                  input bit poke_unused, input bit squeeze);
    int unsigned sent;
    int unsigned pushed;
    roll_needle();
    load_needle(len_word, poke_unused);
    sent = 0;
    while (sent < PhaseBytes) begin
      push_random_string($urandom_range(1, plan_len + 24), pushed);
      sent += pushed;
    end
    // receiver holds off while the sender keeps offering words
    if (squeeze) squeeze_asked++;
  endtask

  initial begin
    int i;
    clear_string_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset needle is a single zero byte.
    push_word(8'h00, 1'b1);           // zero byte is an ordinary match
    push_text("Q");                   // no match
    push_text("'");                   // lone quote: span still open
    push_word(uss_pkg::SQuote, 1'b0); // zero inside quotes cannot start
    push_word(8'h00, 1'b1);

    // Needle "aB": case folding, quote spans, early verdict.
    for (i = 0; i < uss_pkg::MaxNeedleDflt; i++) plan_bytes[i] = 8'($urandom_range(255));
    plan_bytes[0] = 8'h61;
    plan_bytes[1] = 8'h42;
    load_needle(64'd2, 1'b1);
    push_text("xAb");                 // found at 2
    push_text("\"ab");                // open span early enough: unclosed
    push_text("ab\"");                // found, trailing bytes silent
    push_text("x\"");                 // span opens too late: not found
    push_text("'a\"b'ab");            // other quote inside span, found after it
    push_text("a");                   // shorter than needle

    // Random phases over several needle settings, extremes included.
    run_random_phase(64'd1, 1'b0, 1'b1);
    run_random_phase(64'd16, 1'b0, 1'b0);
    run_random_phase(64'd0, 1'b1, 1'b0);            // zero length acts as one
    run_random_phase({$urandom, $urandom} | 64'h1F, 1'b0, 1'b0);  // clamps to 16
    run_random_phase(64'($urandom_range(2, 8)), 1'b1, 1'b1);

    // Last phase runs with no idling on either side.
    settle();
    calm = 1'b1;
    run_random_phase(64'($urandom_range(9, 15)), 1'b0, 1'b0);
    settle();
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
